// ===== rtl/core/mpcs_pkg.sv =====
// Package for the multiplexed performance counter sampler core.
// Holds beat types, codes, FSM states and sizing constants; depends on nothing.
package mpcs_pkg;

	localparam int MAX_EVENTS = 16;
	localparam int IDX_W      = $clog2(MAX_EVENTS);
	localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
	localparam int ENABLE_BIT = 45;
	localparam int SAMPLE_W   = 40;
	localparam int PERIOD_W   = 10;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_BUSY    = 2'd1,
		STS_FULL    = 2'd2,
		STS_NO_DATA = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;

	typedef struct packed {
		logic [1:0]          kind;
		logic [63:0]         event_select;
		logic [SAMPLE_W-1:0] sample_a;
		logic [SAMPLE_W-1:0] sample_b;
		logic [3:0]          read_index;
		logic                read_side;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        program_valid;
		logic [63:0] program_select;
		logic [63:0] event_out;
		logic [63:0] scaled_count;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] multiplicand;
		logic [31:0] multiplier;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_CMP,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_LINK,
		ST_TICK_DIV,
		ST_TICK_RD,
		ST_TICK_WR,
		ST_TICK_SEL,
		ST_TICK_OUT,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/mpcs_serial_mul.sv =====
// Bit-serial 64 x 32 multiplier, product wraps at 64 bits, one bit per cycle.
// Depends on mpcs_pkg for the request struct.
module mpcs_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mpcs_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       product
);
	logic [63:0] prod_q;
	logic [63:0] mc_q;
	logic [31:0] mp_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= '0;
			mc_q   <= req.multiplicand;
			mp_q   <= req.multiplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				prod_q <= prod_q + mc_q;
			end
			mc_q <= {mc_q[62:0], 1'b0};
			mp_q <= {1'b0, mp_q[31:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;
endmodule

// ===== rtl/core/mpcs_serial_div.sv =====
// Restoring 64 / 32 divider producing one quotient bit per cycle.
// Depends on mpcs_pkg for the request struct.
module mpcs_serial_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mpcs_pkg::div_req_t req,
	output logic               done,
	output logic [63:0]        quotient,
	output logic [31:0]        remainder
);
	logic [32:0] rem_q;
	logic [63:0] dq_q;
	logic [31:0] dv_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], dq_q[63]};
	assign diff    = shifted - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dv_q  <= req.divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				dq_q  <= {dq_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				dq_q  <= {dq_q[62:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q[31:0];
endmodule

// ===== rtl/core/multiplexed_perf_counter_sampler_core.sv =====
// Top level of the multiplexed performance counter sampler core.
// Depends on mpcs_pkg, mpcs_serial_mul and mpcs_serial_div.
//
// Usage. Request beats arrive on req_valid/req_stall/req_data and each one
// produces exactly one response beat on rsp_valid/rsp_stall/rsp_data. A beat
// moves at a clock edge where valid is high and stall is low. The block
// takes one request at a time: req_stall is high from acceptance until the
// response has been loaded into the output register, which may still wait
// for the receiver while the next request is accepted.
// Steps after acceptance: an append goes to done while enabled, writes its
// slot on an empty ring, else reads and compares each entry, then reads,
// writes and links the new slot. A tick goes to done when it cannot rotate,
// else waits on the 64-step serial divider for phase modulo period and, to
// rotate, reads, writes and selects the next entry. A read goes to done when
// refused, else walks to its entry, then multiplies and divides if it has intervals.
// Configuration writes on cfg_valid/cfg_ready are always accepted; index 0
// is counting_enable and index 1 is update_period, other indexes are dropped.
// Reset clears the ring pointers, counters and configuration at once; the
// entry memories need no clearing, since slots are written before use.
// A stalled receiver only holds the response register; the next request
// then completes up to its final step and waits there.
module multiplexed_perf_counter_sampler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  mpcs_pkg::req_t                     req_data,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output mpcs_pkg::rsp_t                     rsp_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpcs_pkg::PERIOD_W-1:0]      cfg_data
);
	localparam int IW = mpcs_pkg::IDX_W;
	localparam int CW = mpcs_pkg::CNT_W;

	// Entry memories, one registered read port at mem_addr.
	logic [63:0]   sel_mem  [mpcs_pkg::MAX_EVENTS];
	logic [IW-1:0] link_mem [mpcs_pkg::MAX_EVENTS];
	logic [63:0]   acca_mem [mpcs_pkg::MAX_EVENTS];
	logic [63:0]   accb_mem [mpcs_pkg::MAX_EVENTS];
	logic [31:0]   own_mem  [mpcs_pkg::MAX_EVENTS];
	logic [31:0]   tot_mem  [mpcs_pkg::MAX_EVENTS];

	logic [63:0]   rd_sel_q, rd_acca_q, rd_accb_q;
	logic [IW-1:0] rd_link_q;
	logic [31:0]   rd_own_q, rd_tot_q;

	mpcs_pkg::state_t state_q, state_d;

	logic                          enable_q;
	logic [mpcs_pkg::PERIOD_W-1:0] period_q;
	logic [IW-1:0]                 first_q, current_q, scan_q, ptr_q;
	logic [CW-1:0]                 used_q;
	logic [31:0]                   phase_q, active_q, own_hold_q;
	logic [3:0]                    walk_cnt_q;
	mpcs_pkg::req_t                req_q;
	mpcs_pkg::rsp_t                res_q, rsp_q;
	mpcs_pkg::rsp_t                res_init, rsp_next;
	logic                          rsp_valid_q;

	// Memory control from the output decode.
	logic [IW-1:0] mem_addr, ent_wa, link_wa, link_wd;
	logic          ent_we, sel_we, link_we;
	logic [63:0]   sel_wd, acca_wd, accb_wd;
	logic [31:0]   own_wd, tot_wd;

	mpcs_pkg::mul_req_t mul_req;
	mpcs_pkg::div_req_t div_req;
	logic               mul_done, div_done;
	logic [63:0]        mul_prod, div_quot;
	logic [31:0]        div_rem;

	logic          accept;
	logic          out_free;
	logic [63:0]   sel_forced;
	logic [9:0]    period_eff;
	logic          tick_go, read_bad;
	logic [IW-1:0] new_slot;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != mpcs_pkg::ST_IDLE);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign cfg_ready  = 1'b1;
	assign sel_forced = req_q.event_select | (64'd1 << mpcs_pkg::ENABLE_BIT);
	assign period_eff = (period_q == '0) ? 10'd1 : period_q;
	assign tick_go    = enable_q && (used_q != '0);
	assign read_bad   = !enable_q || (used_q == '0) || ({1'b0, req_data.read_index} >= used_q);
	assign new_slot   = used_q[IW-1:0];

	mpcs_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_prod)
	);

	mpcs_serial_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpcs_pkg::ST_IDLE: begin
				if (accept) begin
					case (req_data.kind)
						mpcs_pkg::KIND_APPEND: begin
							if (enable_q) state_d = mpcs_pkg::ST_DONE;
							else if (used_q == '0) state_d = mpcs_pkg::ST_INS_WR;
							else state_d = mpcs_pkg::ST_APP_RD;
						end
						mpcs_pkg::KIND_TICK: begin
							state_d = tick_go ? mpcs_pkg::ST_TICK_DIV : mpcs_pkg::ST_DONE;
						end
						mpcs_pkg::KIND_READ: begin
							state_d = read_bad ? mpcs_pkg::ST_DONE : mpcs_pkg::ST_WALK_RD;
						end
						default: state_d = mpcs_pkg::ST_DONE;
					endcase
				end
			end
			mpcs_pkg::ST_APP_RD: state_d = mpcs_pkg::ST_APP_CMP;
			mpcs_pkg::ST_APP_CMP: begin
				if (rd_sel_q == sel_forced) state_d = mpcs_pkg::ST_DONE;
				else if ({1'b0, scan_q} == used_q - CW'(1)) begin
					state_d = (used_q == CW'(mpcs_pkg::MAX_EVENTS)) ? mpcs_pkg::ST_DONE
						: mpcs_pkg::ST_INS_RD;
				end else state_d = mpcs_pkg::ST_APP_RD;
			end
			mpcs_pkg::ST_INS_RD: state_d = mpcs_pkg::ST_INS_WR;
			mpcs_pkg::ST_INS_WR: begin
				state_d = (used_q == '0) ? mpcs_pkg::ST_DONE : mpcs_pkg::ST_INS_LINK;
			end
			mpcs_pkg::ST_INS_LINK: state_d = mpcs_pkg::ST_DONE;
			mpcs_pkg::ST_TICK_DIV: begin
				if (div_done) begin
					state_d = (div_rem == '0) ? mpcs_pkg::ST_TICK_RD : mpcs_pkg::ST_DONE;
				end
			end
			mpcs_pkg::ST_TICK_RD:  state_d = mpcs_pkg::ST_TICK_WR;
			mpcs_pkg::ST_TICK_WR:  state_d = mpcs_pkg::ST_TICK_SEL;
			mpcs_pkg::ST_TICK_SEL: state_d = mpcs_pkg::ST_TICK_OUT;
			mpcs_pkg::ST_TICK_OUT: state_d = mpcs_pkg::ST_DONE;
			mpcs_pkg::ST_WALK_RD:  state_d = mpcs_pkg::ST_WALK_CHK;
			mpcs_pkg::ST_WALK_CHK: begin
				if (walk_cnt_q != '0) state_d = mpcs_pkg::ST_WALK_RD;
				else state_d = (rd_own_q == '0) ? mpcs_pkg::ST_DONE : mpcs_pkg::ST_MUL;
			end
			mpcs_pkg::ST_MUL: if (mul_done) state_d = mpcs_pkg::ST_DIV;
			mpcs_pkg::ST_DIV: if (div_done) state_d = mpcs_pkg::ST_DONE;
			mpcs_pkg::ST_DONE: if (out_free) state_d = mpcs_pkg::ST_IDLE;
			default: state_d = mpcs_pkg::ST_IDLE;
		endcase
	end

	// Output decode: memory ports and arithmetic unit starts.
	always_comb begin
		mem_addr = current_q;
		ent_we   = 1'b0;
		sel_we   = 1'b0;
		link_we  = 1'b0;
		ent_wa   = current_q;
		link_wa  = new_slot;
		link_wd  = new_slot;
		sel_wd   = sel_forced;
		acca_wd  = '0;
		accb_wd  = '0;
		own_wd   = '0;
		tot_wd   = '0;
		mul_req  = '0;
		div_req  = '0;
		case (state_q)
			mpcs_pkg::ST_IDLE: begin
				div_req.start    = accept && (req_data.kind == mpcs_pkg::KIND_TICK) && tick_go;
				div_req.dividend = {32'd0, phase_q};
				div_req.divisor  = {22'd0, period_eff};
			end
			mpcs_pkg::ST_APP_RD: mem_addr = scan_q;
			mpcs_pkg::ST_INS_RD: mem_addr = current_q;
			mpcs_pkg::ST_INS_WR: begin
				ent_we  = 1'b1;
				sel_we  = 1'b1;
				link_we = 1'b1;
				ent_wa  = new_slot;
				link_wa = new_slot;
				link_wd = (used_q == '0) ? new_slot : rd_link_q;
			end
			mpcs_pkg::ST_INS_LINK: begin
				link_we = 1'b1;
				link_wa = current_q;
				link_wd = new_slot;
			end
			mpcs_pkg::ST_TICK_RD: mem_addr = current_q;
			mpcs_pkg::ST_TICK_WR: begin
				ent_we  = 1'b1;
				ent_wa  = current_q;
				acca_wd = rd_acca_q + {24'd0, req_q.sample_a};
				accb_wd = rd_accb_q + {24'd0, req_q.sample_b};
				own_wd  = rd_own_q + 32'd1;
				tot_wd  = active_q + 32'd1;
			end
			mpcs_pkg::ST_TICK_SEL: mem_addr = current_q;
			mpcs_pkg::ST_WALK_RD:  mem_addr = ptr_q;
			mpcs_pkg::ST_WALK_CHK: begin
				mul_req.start        = (walk_cnt_q == '0) && (rd_own_q != '0);
				mul_req.multiplicand = req_q.read_side ? rd_accb_q : rd_acca_q;
				mul_req.multiplier   = rd_tot_q;
			end
			mpcs_pkg::ST_MUL: begin
				div_req.start    = mul_done;
				div_req.dividend = mul_prod;
				div_req.divisor  = own_hold_q;
			end
			default: begin
			end
		endcase
	end

	// Initial result of an accepted request and the beat loaded into the output register.
	always_comb begin
		res_init = '0;
		if ((req_data.kind == mpcs_pkg::KIND_APPEND) && enable_q) begin
			res_init.status = mpcs_pkg::STS_BUSY;
		end
		if ((req_data.kind == mpcs_pkg::KIND_READ) && read_bad) begin
			res_init.status = mpcs_pkg::STS_NO_DATA;
		end
		rsp_next             = res_q;
		rsp_next.entry_count = enable_q ? used_q : '0;
	end

	// Entry memories.
	always_ff @(posedge clk) begin
		if (sel_we) sel_mem[ent_wa] <= sel_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (ent_we) begin
			acca_mem[ent_wa] <= acca_wd;
			accb_mem[ent_wa] <= accb_wd;
			own_mem[ent_wa]  <= own_wd;
			tot_mem[ent_wa]  <= tot_wd;
		end
		rd_sel_q  <= sel_mem[mem_addr];
		rd_link_q <= link_mem[mem_addr];
		rd_acca_q <= acca_mem[mem_addr];
		rd_accb_q <= accb_mem[mem_addr];
		rd_own_q  <= own_mem[mem_addr];
		rd_tot_q  <= tot_mem[mem_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpcs_pkg::ST_IDLE;
			enable_q    <= 1'b0;
			period_q    <= 10'd1;
			first_q     <= '0;
			current_q   <= '0;
			used_q      <= '0;
			phase_q     <= '0;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mpcs_pkg::CFG_ENABLE) enable_q <= cfg_data[0];
				else if (cfg_index == mpcs_pkg::CFG_PERIOD) period_q <= cfg_data;
			end
			if (accept && (req_data.kind == mpcs_pkg::KIND_TICK) && tick_go) begin
				phase_q <= phase_q + 32'd1;
			end
			case (state_q)
				mpcs_pkg::ST_INS_WR: begin
					if (used_q == '0) begin
						first_q   <= new_slot;
						current_q <= new_slot;
						used_q    <= used_q + CW'(1);
					end
				end
				mpcs_pkg::ST_INS_LINK: used_q <= used_q + CW'(1);
				mpcs_pkg::ST_TICK_WR: begin
					active_q  <= active_q + 32'd1;
					current_q <= rd_link_q;
				end
				default: begin
				end
			endcase
			if ((state_q == mpcs_pkg::ST_DONE) && out_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// Request copy, walk pointers and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_data;
			res_q  <= res_init;
			scan_q <= '0;
			ptr_q  <= first_q;
			walk_cnt_q <= req_data.read_index;
		end
		case (state_q)
			mpcs_pkg::ST_APP_CMP: begin
				scan_q <= scan_q + IW'(1);
				if ((rd_sel_q != sel_forced) && ({1'b0, scan_q} == used_q - CW'(1))
					&& (used_q == CW'(mpcs_pkg::MAX_EVENTS))) begin
					res_q.status <= mpcs_pkg::STS_FULL;
				end
			end
			mpcs_pkg::ST_TICK_OUT: begin
				res_q.program_valid  <= 1'b1;
				res_q.program_select <= rd_sel_q;
			end
			mpcs_pkg::ST_WALK_CHK: begin
				ptr_q      <= rd_link_q;
				walk_cnt_q <= walk_cnt_q - 4'd1;
				own_hold_q <= rd_own_q;
				if (walk_cnt_q == '0) res_q.event_out <= rd_sel_q;
			end
			mpcs_pkg::ST_DIV: if (div_done) res_q.scaled_count <= div_quot;
			default: begin
			end
		endcase
		if ((state_q == mpcs_pkg::ST_DONE) && out_free) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
endmodule

// ===== rtl/core/mpcs_checker.sv =====
// Port-level checker for the sampler core, bound to the top level.
// Depends on mpcs_pkg for the beat types and status codes.
module mpcs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input mpcs_pkg::rsp_t rsp_data
);
	// A stalled response beat holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// A rotation only happens on a non-empty ring and always reports ok.
	a_rotate_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.program_valid |->
		rsp_data.status == mpcs_pkg::STS_OK && rsp_data.entry_count != 5'd0)
		else $error("rotation with bad status or empty ring");

	// The ring never reports more entries than it holds.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.entry_count <= 5'(mpcs_pkg::MAX_EVENTS))
		else $error("entry count out of range");

	// A scaled count only comes from a successful read of a stored selector.
	a_scaled_src: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.scaled_count != 64'd0 |->
		rsp_data.status == mpcs_pkg::STS_OK && rsp_data.event_out[mpcs_pkg::ENABLE_BIT])
		else $error("scaled count without a valid read");
endmodule

bind multiplexed_perf_counter_sampler_core mpcs_checker u_mpcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

// ===== tb/multiplexed_perf_counter_sampler_core_tb.sv =====
// Self-checking testbench for the multiplexed performance counter sampler core.
// Depends on mpcs_pkg and the core; predicts every response beat in its own model.
module multiplexed_perf_counter_sampler_core_tb;
	import mpcs_pkg::*;

	// Idle window after the last response beat, longer than the slowest request.
	localparam int DRAIN_CYCLES  = 200;
	// Stuck cycles allowed before the run is declared hung.
	localparam int HANG_LIMIT    = 20000;
	localparam int RANDOM_ITEMS  = 900;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PERIOD_W-1:0] cfg_data;

	multiplexed_perf_counter_sampler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the ring and the sampling state.
	logic [63:0] ring_sel [MAX_EVENTS];
	logic [IDX_W-1:0] ring_next [MAX_EVENTS];
	logic [63:0] sum_a [MAX_EVENTS];
	logic [63:0] sum_b [MAX_EVENTS];
	logic [31:0] slot_intervals [MAX_EVENTS];
	logic [31:0] slot_total [MAX_EVENTS];
	logic [IDX_W-1:0] head_slot;
	logic [IDX_W-1:0] cur_slot;
	int unsigned ring_len;
	logic [31:0] phase_cnt;
	logic [31:0] rotations;
	logic enabled;
	logic [PERIOD_W-1:0] period;

	rsp_t pending_rsp [$];
	int mismatches = 0;
	int hang_cycles = 0;
	// Idling controls; quiet disables random gaps on both sides.
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit idle_roll();
		return !quiet && ($urandom_range(99) < 7);
	endfunction

	// Computes the response to one request and updates the shadow state.
	function automatic rsp_t sampler_predict(req_t r);
		rsp_t o;
		logic [63:0] sel;
		logic [IDX_W-1:0] p;
		logic [IDX_W-1:0] n;
		logic [31:0] per;
		logic [63:0] c;
		bit dup;
		o = '0;
		case (kind_t'(r.kind))
			KIND_APPEND: begin
				sel = r.event_select | (64'd1 << ENABLE_BIT);
				dup = 1'b0;
				if (enabled) begin
					o.status = STS_BUSY;
				end else begin
					p = head_slot;
					for (int i = 0; i < ring_len; i++) begin
						if (ring_sel[p] == sel) dup = 1'b1;
						p = ring_next[p];
					end
					if (dup) begin
						o.status = STS_OK;
					end else if (ring_len >= MAX_EVENTS) begin
						o.status = STS_FULL;
					end else begin
						n = IDX_W'(ring_len);
						ring_sel[n] = sel;
						sum_a[n] = '0;
						sum_b[n] = '0;
						slot_intervals[n] = '0;
						slot_total[n] = '0;
						if (ring_len == 0) begin
							ring_next[n] = n;
							head_slot = n;
							cur_slot = n;
						end else begin
							ring_next[n] = ring_next[cur_slot];
							ring_next[cur_slot] = n;
						end
						ring_len++;
					end
				end
			end
			KIND_TICK: begin
				if (enabled && ring_len > 0) begin
					per = (period == 0) ? 32'd1 : 32'(period);
					if (phase_cnt % per == 0) begin
						rotations = rotations + 1;
						slot_intervals[cur_slot] = slot_intervals[cur_slot] + 1;
						slot_total[cur_slot] = rotations;
						sum_a[cur_slot] = sum_a[cur_slot] + 64'(r.sample_a);
						sum_b[cur_slot] = sum_b[cur_slot] + 64'(r.sample_b);
						cur_slot = ring_next[cur_slot];
						o.program_valid = 1'b1;
						o.program_select = ring_sel[cur_slot];
					end
					phase_cnt = phase_cnt + 1;
				end
			end
			KIND_READ: begin
				if (!enabled || ring_len == 0 || r.read_index >= ring_len) begin
					o.status = STS_NO_DATA;
				end else begin
					p = head_slot;
					for (int i = 0; i < r.read_index; i++) p = ring_next[p];
					o.event_out = ring_sel[p];
					if (slot_intervals[p] != 0) begin
						c = r.read_side ? sum_b[p] : sum_a[p];
						o.scaled_count = (c * 64'(slot_total[p])) / 64'(slot_intervals[p]);
					end
				end
			end
			default: ;
		endcase
		o.entry_count = enabled ? 5'(ring_len) : 5'd0;
		return o;
	endfunction

	// Sends one request beat and queues its expected response.
	task automatic send_request(req_t r);
		while (idle_roll()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(sampler_predict(r));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one register; only called while no response is outstanding.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_ENABLE) enabled = val[0];
		else if (idx == CFG_PERIOD) period = val;
	endtask

	function automatic req_t make_req(kind_t k, logic [63:0] sel, logic [39:0] a,
			logic [39:0] b, logic [3:0] idx, logic side);
		req_t r;
		r.kind = k;
		r.event_select = sel;
		r.sample_a = a;
		r.sample_b = b;
		r.read_index = idx;
		r.read_side = side;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [39:0] rand40();
		return 40'({$urandom(), $urandom()});
	endfunction

	function automatic req_t rand_req(kind_t k);
		return make_req(k, rand64(), rand40(), rand40(), 4'($urandom_range(15)),
			1'($urandom_range(1)));
	endfunction

	// Directed: status codes, extremes of the fields and each special case.
	task automatic test_directed();
		send_request(make_req(KIND_READ, '0, '0, '0, 4'd0, 1'b0));   // disabled read
		send_request(make_req(KIND_TICK, '0, '1, '1, 4'd0, 1'b0));   // empty ring tick
		send_request(make_req(KIND_APPEND, '0, '0, '0, 4'd0, 1'b0));
		send_request(make_req(KIND_APPEND, '1, '0, '0, 4'd0, 1'b0));
		send_request(make_req(KIND_APPEND, 64'd1 << ENABLE_BIT, '0, '0, 4'd0, 1'b0)); // dup
		send_request(make_req(KIND_APPEND, 64'h5555_5555_5555_5555, '0, '0, 4'd0, 1'b0));
		send_request(make_req(KIND_NOP, '1, '1, '1, 4'hf, 1'b1));
		write_reg(CFG_ENABLE, 10'd1);
		send_request(make_req(KIND_APPEND, 64'h1234, '0, '0, 4'd0, 1'b0)); // busy
		for (int i = 0; i < 6; i++)
			send_request(make_req(KIND_TICK, '0, '1, '1, 4'd0, 1'b0));
		send_request(make_req(KIND_READ, '0, '0, '0, 4'd0, 1'b0));
		send_request(make_req(KIND_READ, '0, '0, '0, 4'd2, 1'b1));
		send_request(make_req(KIND_READ, '0, '0, '0, 4'd3, 1'b0));  // past the count
		send_request(make_req(KIND_READ, '0, '0, '0, 4'hf, 1'b1));
		write_reg(CFG_PERIOD, 10'd0);                               // zero acts as one
		send_request(make_req(KIND_TICK, '0, '0, '0, 4'd0, 1'b0));
		write_reg(CFG_PERIOD, 10'd1023);
		send_request(make_req(KIND_TICK, '0, 40'd1, 40'd2, 4'd0, 1'b0));
		send_request(make_req(KIND_TICK, '0, 40'd1, 40'd2, 4'd0, 1'b0));
		write_reg(CFG_ENABLE, 10'd0);
	endtask

	// Fills the ring past full; then a random tick and read mix while enabled.
	task automatic test_full_ring();
		for (int i = 0; i < MAX_EVENTS + 3; i++) send_request(rand_req(KIND_APPEND));
		write_reg(CFG_PERIOD, 10'd1);
		write_reg(CFG_ENABLE, 10'd1);
		for (int i = 0; i < 60; i++)
			send_request(rand_req($urandom_range(1) ? KIND_TICK : KIND_READ));
		// Hold the sender until every outstanding response has arrived.
		wait_drained();
		send_request(make_req(KIND_READ, '0, '0, '0, 4'd15, 1'b1));
		write_reg(CFG_ENABLE, 10'd0);
	endtask

	// Random phases: a few appends, then mostly ticks and reads, several periods.
	task automatic test_random();
		int done;
		kind_t k;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			write_reg(CFG_ENABLE, 10'd0);
			for (int i = 0; i < $urandom_range(4); i++) begin
				// Reuse selectors now and then to hit the duplicate path.
				send_request($urandom_range(3) == 0 ?
					make_req(KIND_APPEND, ring_sel[0], '0, '0, 4'd0, 1'b0) :
					rand_req(KIND_APPEND));
				done++;
			end
			write_reg(CFG_PERIOD, $urandom_range(3) == 0 ? 10'($urandom_range(1023)) :
				10'($urandom_range(4)));
			write_reg(CFG_ENABLE, 10'd1);
			// The first phase always runs without any idling.
			quiet = (done < 5) || ($urandom_range(5) == 0);
			for (int i = 0; i < 60; i++) begin
				case ($urandom_range(9))
					0: k = KIND_APPEND;
					1: k = KIND_NOP;
					2, 3, 4: k = KIND_READ;
					default: k = KIND_TICK;
				endcase
				send_request(rand_req(k));
				done++;
			end
			quiet = 1'b0;
		end
	endtask

	// Response checker: compares each accepted beat with the oldest prediction.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response beat %h", rsp_data);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_data !== exp_rsp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp sts %0d pv %0d ps %h ev %h sc %h n %0d, got sts %0d pv %0d ps %h ev %h sc %h n %0d",
							exp_rsp.status, exp_rsp.program_valid, exp_rsp.program_select,
							exp_rsp.event_out, exp_rsp.scaled_count, exp_rsp.entry_count,
							rsp_data.status, rsp_data.program_valid, rsp_data.program_select,
							rsp_data.event_out, rsp_data.scaled_count, rsp_data.entry_count);
				end
			end
		end
	end

	// Receiver side stalls at random, except during quiet stretches.
	always @(posedge clk) rsp_stall <= idle_roll();

	// Watchdog on cycles in which a request is offered and no beat is accepted.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready) || !req_valid)
			hang_cycles <= 0;
		else
			hang_cycles <= hang_cycles + 1;
		if (hang_cycles >= HANG_LIMIT || (pending_rsp.size() != 0 &&
				hang_cycles >= HANG_LIMIT)) begin
			$display("[multiplexed_perf_counter_sampler_core] ERROR");
			$finish;
		end
	end

	// A separate timer catches a drain that never finishes.
	int drain_wait = 0;
	always @(posedge clk) begin
		if (pending_rsp.size() != 0 && !(rsp_valid && !rsp_stall)) drain_wait <= drain_wait + 1;
		else drain_wait <= 0;
		if (drain_wait >= HANG_LIMIT) begin
			$display("[multiplexed_perf_counter_sampler_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		for (int i = 0; i < MAX_EVENTS; i++) begin
			ring_sel[i] = '0;
			ring_next[i] = '0;
			sum_a[i] = '0;
			sum_b[i] = '0;
			slot_intervals[i] = '0;
			slot_total[i] = '0;
		end
		head_slot = '0;
		cur_slot = '0;
		ring_len = 0;
		phase_cnt = '0;
		rotations = '0;
		enabled = 1'b0;
		period = 10'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_ring();
		test_random();
		wait_drained();
		if (mismatches == 0)
			$display("[multiplexed_perf_counter_sampler_core] OK");
		else
			$display("[multiplexed_perf_counter_sampler_core] ERROR");
		$finish;
	end

endmodule
